### rtl/core/kmu_pkg.sv
// ----------------------------------------------------------------------------
// kmu_pkg
// Types, codes and helpers shared by the two-axis Kalman update block.
// ----------------------------------------------------------------------------
package kmu_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DEN_W         = 34;

  localparam logic [30:0] POS_BASE_RST = 31'd131072;
  localparam logic [30:0] VEL_BASE_RST = 31'd393216;
  localparam logic [30:0] INIT_VAR_RST = 31'd65536;

  localparam logic [7:0]  QUAL_MAX     = 8'd255;
  localparam int          NOISE_MUL_P  = 80;
  localparam int          NOISE_MUL_V  = 40;
  // divide by 8000 and 4000: shift out 2^6 or 2^5, then divide by 125
  localparam int          NOISE_SH_P   = 6;
  localparam int          NOISE_SH_V   = 5;
  // ceil(2^35 / 125), exact for every 32-bit dividend
  localparam logic [31:0] NOISE_RCP    = 32'h10624dd3;
  localparam int          NOISE_RCP_SH = 35;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  typedef enum logic [2:0] {
    CMD_FLOW  = 3'd0,
    CMD_POS   = 3'd1,
    CMD_VEL   = 3'd2,
    CMD_ALIGN = 3'd3,
    CMD_INIT  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_POS_BASE = 2'd0,
    CFG_VEL_BASE = 2'd1,
    CFG_INIT_VAR = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    L_IDLE,
    L_NDIV_P,
    L_NDIV_V,
    L_START,
    L_DIV1,
    L_DIV2,
    L_MUL,
    L_DONE
  } lane_st_t;

  typedef struct packed {
    logic [30:0] pos_base;
    logic [30:0] vel_base;
    logic [30:0] init_var;
  } cfg_t;

  typedef struct packed {
    cmd_t               cmd;
    logic               do_init;
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic [7:0]         quality;
    logic [30:0]        noise;
  } lane_req_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic               fault;
  } lane_res_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = S32_MAX;
    else if (v < -66'sd2147483648) r = S32_MIN;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic [31:0] r;
    if (v[31]) r = ~v + 32'd1;
    else r = v;
    return r;
  endfunction

endpackage

### rtl/core/kmu_in_if.sv
// ----------------------------------------------------------------------------
// kmu_in_if
// Input channel: command and measurements for both axes.
// ----------------------------------------------------------------------------
interface kmu_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic [7:0]         quality;
  logic [30:0]        noise_x;
  logic [30:0]        noise_y;

  modport source (output valid, command, pos_x, pos_y, vel_x, vel_y, quality,
                  noise_x, noise_y, input ready);
  modport sink (input valid, command, pos_x, pos_y, vel_x, vel_y, quality,
                noise_x, noise_y, output ready);
endinterface

### rtl/core/kmu_out_if.sv
// ----------------------------------------------------------------------------
// kmu_out_if
// Result channel: state estimates of both axes and the fault flag.
// ----------------------------------------------------------------------------
interface kmu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] est_pos_x;
  logic signed [31:0] est_vel_x;
  logic signed [31:0] est_pos_y;
  logic signed [31:0] est_vel_y;
  logic               div_fault;

  modport source (output valid, est_pos_x, est_vel_x, est_pos_y, est_vel_y,
                  div_fault, input ready);
  modport sink (input valid, est_pos_x, est_vel_x, est_pos_y, est_vel_y,
                div_fault, output ready);
endinterface

### rtl/core/two_axis_kalman_measurement_update.sv
// ----------------------------------------------------------------------------
// two_axis_kalman_measurement_update
// Two two-state Kalman filters, X and Y, updated side by side in two lanes.
// ----------------------------------------------------------------------------
// Each accepted item yields one result. The X and Y lanes run in parallel and
// the result is sent when both have finished. Each lane has one serial divider
// giving one quotient bit a cycle. A measurement update is a set-up step, two
// gain divisions and the multiply steps; a skipped update ends after set-up.
// The flow noises come from a reciprocal multiplication. A flow command runs
// the position and then the velocity update, a position or velocity command
// one update, and realign, init or an unused code none. The result is
// registered in the output stage once both lanes finish and that stage is
// free or being emptied. A new item is taken once both lanes are idle, while a
// finished result may still wait in the output stage; a stalled output holds
// the lanes.
// ----------------------------------------------------------------------------
module two_axis_kalman_measurement_update
  import kmu_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data,
  kmu_in_if.sink      in_ch,
  kmu_out_if.source   out_ch
);

  cfg_t      cfg_r, cfg_nxt;
  logic      rdy_r, rdy_nxt;
  logic      idle_x, idle_y, accept, take;
  cmd_t      cmd;
  lane_req_t req_x, req_y;
  lane_res_t res_x, res_y;

  assign cmd          = cmd_t'(in_ch.command);
  assign in_ch.ready  = idle_x && idle_y;
  assign accept       = in_ch.valid && in_ch.ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_POS_BASE: cfg_nxt.pos_base = cfg_data;
        CFG_VEL_BASE: cfg_nxt.vel_base = cfg_data;
        CFG_INIT_VAR: cfg_nxt.init_var = cfg_data;
        default:      ;
      endcase
    end
    rdy_nxt = rdy_r;
    if (accept && (cmd == CMD_FLOW || cmd == CMD_INIT)) rdy_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{pos_base: POS_BASE_RST, vel_base: VEL_BASE_RST,
                 init_var: INIT_VAR_RST};
      rdy_r <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
      rdy_r <= rdy_nxt;
    end
  end

  always_comb begin
    req_x.cmd     = cmd;
    req_x.do_init = (cmd == CMD_FLOW) && !rdy_r;
    req_x.pos     = in_ch.pos_x;
    req_x.vel     = in_ch.vel_x;
    req_x.quality = in_ch.quality;
    req_x.noise   = in_ch.noise_x;
    req_y         = req_x;
    req_y.pos     = in_ch.pos_y;
    req_y.vel     = in_ch.vel_y;
    req_y.noise   = in_ch.noise_y;
  end

  kmu_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
    .clk  (clk),
    .rst_n(rst_n),
    .start(accept),
    .req  (req_x),
    .cfg  (cfg_r),
    .take (take),
    .res  (res_x),
    .idle (idle_x)
  );

  kmu_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
    .clk  (clk),
    .rst_n(rst_n),
    .start(accept),
    .req  (req_y),
    .cfg  (cfg_r),
    .take (take),
    .res  (res_y),
    .idle (idle_y)
  );

  kmu_merge u_merge (
    .clk   (clk),
    .rst_n (rst_n),
    .res_x (res_x),
    .res_y (res_y),
    .take  (take),
    .out_ch(out_ch)
  );

endmodule

### rtl/core/kmu_div.sv
// ----------------------------------------------------------------------------
// kmu_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kmu_div
  import kmu_pkg::*;
#(
  parameter int DW = 32 + FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [DW-1:0]    num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [DW-1:0]    quo
);

  localparam int CW = $clog2(DW);

  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [CW-1:0]    cnt_r;
  logic [DEN_W:0]   rem_r;
  logic [DW-1:0]    quo_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem_r[DEN_W-1:0], quo_r[DW-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (go) begin
      run_nxt = 1'b1;
    end else if (run_r && cnt_r == '0) begin
      run_nxt  = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
      cnt_r <= CW'(DW - 1);
    end else if (run_r) begin
      rem_r <= ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
      quo_r <= {quo_r[DW-2:0], ge};
      cnt_r <= cnt_r - CW'(1);
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

### rtl/core/kmu_lane.sv
// ----------------------------------------------------------------------------
// kmu_lane
// One axis filter: state, covariance, gain division and update sequencer.
// ----------------------------------------------------------------------------
module kmu_lane
  import kmu_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  lane_req_t req,
  input  cfg_t      cfg,
  input  logic      take,
  output lane_res_t res,
  output logic      idle
);

  localparam int                DW        = 32 + FRAC_BITS;
  localparam logic [2:0]        LAST_STEP = 3'd5;

  lane_st_t st_r, st_nxt;
  lane_req_t req_r, req_nxt;
  logic signed [31:0] x_r, x_nxt, v_r, v_nxt;
  logic signed [31:0] p00_r, p00_nxt, p01_r, p01_nxt, p10_r, p10_nxt, p11_r, p11_nxt;
  logic signed [31:0] c00_r, c00_nxt, c01_r, c01_nxt, c10_r, c10_nxt, c11_r, c11_nxt;
  logic [31:0]        rp_r, rp_nxt, rv_r, rv_nxt, rsel_r, rsel_nxt;
  logic [31:0]        nd_r, nd_nxt;
  logic               vel_r, vel_nxt, fault_r, fault_nxt, sgn_r, sgn_nxt, ph_r, ph_nxt;
  logic [DEN_W-1:0]   s_r, s_nxt;
  logic signed [31:0] e_r, e_nxt, nb_r, nb_nxt, k1_r, k1_nxt, k2_r, k2_nxt;
  logic [2:0]         step_r, step_nxt;
  logic signed [63:0] prod_r, prod_nxt;

  logic             div_go, div_done;
  logic [DW-1:0]    div_num, div_quo;
  logic [DEN_W-1:0] div_den;

  logic signed [31:0] sp, na, nb, iv, kval, k_sel, b_sel, old_v, e_calc, wr_v;
  logic signed [33:0] s_full;
  logic               s_bad, more, gpos_big, gneg_big;
  logic [DW-1:0]      np, nv;
  logic signed [63:0] qv;
  logic [63:0]        rcp_prod;
  logic [31:0]        rcp_q;

  kmu_div #(.DW(DW)) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (div_go),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  assign sp     = vel_r ? p11_r : p00_r;
  assign na     = vel_r ? p01_r : p00_r;
  assign nb     = vel_r ? p11_r : p10_r;
  assign s_full = {{2{sp[31]}}, sp} + $signed({2'b00, rsel_r});
  assign s_bad  = s_full[33] || (s_full == '0);
  assign more   = !vel_r && (req_r.cmd == CMD_FLOW);
  assign iv     = {1'b0, cfg.init_var};
  assign e_calc = sat32(66'(req_r.vel) - 66'(v_r));

  assign np = DW'(cfg.pos_base) * DW'(NOISE_MUL_P)
            + (DW'(QUAL_MAX - req.quality) << FRAC_BITS);
  assign nv = DW'(cfg.vel_base) * DW'(NOISE_MUL_V)
            + (DW'(QUAL_MAX - req_r.quality) << FRAC_BITS);

  assign rcp_prod = nd_r * NOISE_RCP;
  assign rcp_q    = 32'(rcp_prod >> NOISE_RCP_SH);

  assign gpos_big = |div_quo[DW-1:31];
  assign gneg_big = (|div_quo[DW-1:32]) || (div_quo[31] && (|div_quo[30:0]));
  always_comb begin
    if (sgn_r) kval = gneg_big ? S32_MIN : $signed(~div_quo[31:0] + 32'd1);
    else kval = gpos_big ? S32_MAX : $signed(div_quo[31:0]);
  end

  always_comb begin
    k_sel = (step_r == 3'd0 || step_r == 3'd2 || step_r == 3'd3) ? k1_r : k2_r;
    if (step_r < 3'd2) b_sel = e_r;
    else if (vel_r) b_sel = step_r[0] ? c11_r : c10_r;
    else b_sel = step_r[0] ? c01_r : c00_r;
    case (step_r)
      3'd0:    old_v = x_r;
      3'd1:    old_v = v_r;
      3'd2:    old_v = c00_r;
      3'd3:    old_v = c01_r;
      3'd4:    old_v = c10_r;
      default: old_v = c11_r;
    endcase
  end

  assign prod_nxt = k_sel * b_sel;
  assign qv       = prod_r >>> FRAC_BITS;
  assign wr_v     = (step_r < 3'd2) ? sat32(66'(old_v) + 66'(qv))
                                    : sat32(66'(old_v) - 66'(qv));

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      L_IDLE: begin
        if (start) begin
          case (req.cmd)
            CMD_FLOW:         st_nxt = L_NDIV_P;
            CMD_POS, CMD_VEL: st_nxt = L_START;
            default:          st_nxt = L_DONE;
          endcase
        end
      end
      L_NDIV_P: st_nxt = L_NDIV_V;
      L_NDIV_V: st_nxt = L_START;
      L_START:  st_nxt = s_bad ? (more ? L_START : L_DONE) : L_DIV1;
      L_DIV1:   if (div_done) st_nxt = L_DIV2;
      L_DIV2:   if (div_done) st_nxt = L_MUL;
      L_MUL: begin
        if (ph_r && step_r == LAST_STEP) st_nxt = more ? L_START : L_DONE;
      end
      L_DONE:   if (take) st_nxt = L_IDLE;
      default:  st_nxt = L_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    req_nxt = req_r; x_nxt = x_r; v_nxt = v_r;
    p00_nxt = p00_r; p01_nxt = p01_r; p10_nxt = p10_r; p11_nxt = p11_r;
    c00_nxt = c00_r; c01_nxt = c01_r; c10_nxt = c10_r; c11_nxt = c11_r;
    rp_nxt = rp_r; rv_nxt = rv_r; rsel_nxt = rsel_r; nd_nxt = nd_r;
    vel_nxt = vel_r; fault_nxt = fault_r; sgn_nxt = sgn_r; ph_nxt = ph_r;
    s_nxt = s_r; e_nxt = e_r; nb_nxt = nb_r; k1_nxt = k1_r; k2_nxt = k2_r;
    step_nxt = step_r;
    div_go = 1'b0; div_num = '0; div_den = '0;
    case (st_r)
      L_IDLE: begin
        if (start) begin
          req_nxt   = req;
          fault_nxt = 1'b0;
          vel_nxt   = (req.cmd == CMD_VEL);
          rsel_nxt  = {1'b0, req.noise};
          case (req.cmd)
            CMD_FLOW: begin
              if (req.do_init) begin
                x_nxt = '0; v_nxt = '0;
                p00_nxt = iv; p01_nxt = '0; p10_nxt = '0; p11_nxt = iv;
              end
              nd_nxt = np[NOISE_SH_P +: 32];
            end
            CMD_ALIGN: begin
              x_nxt = req.pos; v_nxt = req.vel;
            end
            CMD_INIT: begin
              x_nxt = req.pos; v_nxt = req.vel;
              p00_nxt = iv; p01_nxt = '0; p10_nxt = '0; p11_nxt = iv;
            end
            default: ;
          endcase
        end
      end
      L_NDIV_P: begin
        rp_nxt = rcp_q;
        nd_nxt = nv[NOISE_SH_V +: 32];
      end
      L_NDIV_V: begin
        rv_nxt   = rcp_q;
        rsel_nxt = rp_r;
      end
      L_START: begin
        if (s_bad) begin
          fault_nxt = 1'b1;
          if (more) begin
            vel_nxt = 1'b1; rsel_nxt = rv_r;
          end
        end else begin
          c00_nxt = p00_r; c01_nxt = p01_r; c10_nxt = p10_r; c11_nxt = p11_r;
          e_nxt   = vel_r ? e_calc : req_r.pos;
          s_nxt   = s_full[DEN_W-1:0];
          sgn_nxt = na[31];
          nb_nxt  = nb;
          div_go  = 1'b1;
          div_num = {mag32(na), {FRAC_BITS{1'b0}}};
          div_den = s_full[DEN_W-1:0];
        end
      end
      L_DIV1: begin
        if (div_done) begin
          k1_nxt  = kval;
          sgn_nxt = nb_r[31];
          div_go  = 1'b1;
          div_num = {mag32(nb_r), {FRAC_BITS{1'b0}}};
          div_den = s_r;
        end
      end
      L_DIV2: begin
        if (div_done) begin
          k2_nxt = kval; step_nxt = '0; ph_nxt = 1'b0;
        end
      end
      L_MUL: begin
        if (!ph_r) begin
          ph_nxt = 1'b1;
        end else begin
          ph_nxt   = 1'b0;
          step_nxt = step_r + 3'd1;
          case (step_r)
            3'd0:    x_nxt = wr_v;
            3'd1:    v_nxt = wr_v;
            3'd2:    p00_nxt = wr_v;
            3'd3:    p01_nxt = wr_v;
            3'd4:    p10_nxt = wr_v;
            default: p11_nxt = wr_v;
          endcase
          if (step_r == LAST_STEP && more) begin
            vel_nxt = 1'b1; rsel_nxt = rv_r;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= L_IDLE;
      fault_r <= 1'b0;
      x_r <= '0; v_r <= '0;
      p00_r <= '0; p01_r <= '0; p10_r <= '0; p11_r <= '0;
    end else begin
      st_r <= st_nxt;
      fault_r <= fault_nxt;
      x_r <= x_nxt; v_r <= v_nxt;
      p00_r <= p00_nxt; p01_r <= p01_nxt; p10_r <= p10_nxt; p11_r <= p11_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    c00_r <= c00_nxt; c01_r <= c01_nxt; c10_r <= c10_nxt; c11_r <= c11_nxt;
    rp_r <= rp_nxt; rv_r <= rv_nxt; rsel_r <= rsel_nxt; nd_r <= nd_nxt;
    vel_r <= vel_nxt; sgn_r <= sgn_nxt; ph_r <= ph_nxt;
    s_r <= s_nxt; e_r <= e_nxt; nb_r <= nb_nxt; k1_r <= k1_nxt; k2_r <= k2_nxt;
    step_r <= step_nxt;
    prod_r <= prod_nxt;
  end

  assign res.valid = (st_r == L_DONE);
  assign res.pos   = x_r;
  assign res.vel   = v_r;
  assign res.fault = fault_r;
  assign idle      = (st_r == L_IDLE);

endmodule

### rtl/core/kmu_merge.sv
// ----------------------------------------------------------------------------
// kmu_merge
// Join the two lane results into one output transfer with its own register.
// ----------------------------------------------------------------------------
module kmu_merge
  import kmu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  lane_res_t res_x,
  input  lane_res_t res_y,
  output logic      take,
  kmu_out_if.source out_ch
);

  logic               vld_r, vld_nxt;
  logic signed [31:0] px_r, vx_r, py_r, vy_r;
  logic               flt_r;

  assign take = res_x.valid && res_y.valid && (!vld_r || out_ch.ready);

  always_comb begin
    vld_nxt = vld_r;
    if (take) vld_nxt = 1'b1;
    else if (out_ch.ready) vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      px_r  <= res_x.pos;
      vx_r  <= res_x.vel;
      py_r  <= res_y.pos;
      vy_r  <= res_y.vel;
      flt_r <= res_x.fault | res_y.fault;
    end
  end

  assign out_ch.valid     = vld_r;
  assign out_ch.est_pos_x = px_r;
  assign out_ch.est_vel_x = vx_r;
  assign out_ch.est_pos_y = py_r;
  assign out_ch.est_vel_y = vy_r;
  assign out_ch.div_fault = flt_r;

endmodule

### rtl/core/kmu_check.sv
// ----------------------------------------------------------------------------
// kmu_check
// Port-level checks on the Kalman update block, bound to the top level.
// ----------------------------------------------------------------------------
module kmu_check (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] est_pos_x,
  input logic               div_fault
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(est_pos_x) && $stable(div_fault))
    else $error("result changed while stalled");

  // one item at a time: a transfer in makes the lanes busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready held after a transfer");

  // reset empties the output stage
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind two_axis_kalman_measurement_update kmu_check u_kmu_check (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_ch.valid),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .est_pos_x(out_ch.est_pos_x),
  .div_fault(out_ch.div_fault)
);
